>>> rtl/core/hls2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hls2rgb_pkg
// Widths, fixed-point constants and small helpers for the HLS to RGB datapath
// ----------------------------------------------------------------------------
package hls2rgb_pkg;

    localparam int HUE_W     = 15;   // hue, 1/64 degree
    localparam int Q_W       = 17;   // Q1.16 fraction, 65536 is one
    localparam int FAC_W     = 12;   // ramp factor, 0..3840
    localparam int CH_W      = 16;   // output channel
    localparam int NUM_CH    = 3;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 48;

    // channel order: red, green, blue
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam logic [15:0]    TURN     = 16'd23040;
    localparam logic [15:0]    DEG120   = 16'd7680;
    localparam logic [15:0]    DEG240   = 16'd15360;
    localparam logic [14:0]    H_DEG60  = 15'd3840;
    localparam logic [14:0]    H_DEG180 = 15'd11520;
    localparam logic [14:0]    H_DEG240 = 15'd15360;
    localparam logic [Q_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [Q_W-1:0] HALF_Q16 = 17'd32768;

    // floor(a / 15) = (a * RECIP15) >> RECIP_SH, exact for a < 2^20
    localparam logic [20:0] RECIP15  = 21'd1118482;
    localparam int          RECIP_SH = 24;

    typedef logic [HUE_W-1:0] t_hue;
    typedef logic [Q_W-1:0]   t_q16;
    typedef logic [FAC_W-1:0] t_fac;
    typedef logic [CH_W-1:0]  t_chan;

    // subtract one turn at most once
    function automatic t_hue wrap_turn(input logic [15:0] h);
        logic [15:0] w;
        w = (h >= TURN) ? (h - TURN) : h;
        return w[HUE_W-1:0];
    endfunction

    // weight of (m2 - m1) over 60 degrees: rising ramp, plateau, falling ramp, floor
    function automatic t_fac ramp_factor(input t_hue x);
        logic [14:0] d;
        t_fac        f;
        d = H_DEG240 - x;
        if (x < H_DEG60) begin
            f = x[FAC_W-1:0];
        end else if (x < H_DEG180) begin
            f = H_DEG60[FAC_W-1:0];
        end else if (x < H_DEG240) begin
            f = d[FAC_W-1:0];
        end else begin
            f = '0;
        end
        return f;
    endfunction

endpackage

>>> rtl/core/hls_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hls_to_rgb_converter
// Six-stage pipelined conversion of hue, lightness, saturation to 16-bit RGB
// ----------------------------------------------------------------------------
// Takes one HLS beat per clock while the pipeline is not full and stalled,
// and returns one RGB beat per input beat, in order, from the output register.
// Throughput is one pixel per clock while the output side is not stalled; the
// per-stage handshake lets bubbles collapse, so the input keeps flowing while
// a finished pixel waits at the output register, as long as an empty stage
// remains. Hue is in 1/64 degree (one turn is 23040; values up to 32767 are
// wrapped once), lightness and saturation are Q1.16 (65536 is one, larger
// values clamp to one). Pipeline: 1 hue wrap, channel offsets and clamping,
// 2 l*s multiply and ramp factors, 3 m1 / m2 / span, 4 span*factor multiply,
// 5 divide by 60 degrees as shift plus reciprocal multiply, 6 add m1 and scale
// to 16 bits into the output register. Zero saturation falls out as gray
// because m1 equals m2 equals l then.
// ----------------------------------------------------------------------------
module hls_to_rgb_converter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [14:0] hue, [31:15] lightness, [48:32] saturation, [55:49] zero
    input  logic [hls2rgb_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [15:0] red, [31:16] green, [47:32] blue
    output logic [hls2rgb_pkg::M_TDATA_W-1:0]  o_m_axis_tdata
);
    import hls2rgb_pkg::*;

    localparam int NSTG = 6;

    // valid bit per stage, advance enable per stage
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] adv;

    // stage 1: wrapped channel hues, clamped l and s
    t_hue  r1_hue [NUM_CH];
    t_q16  r1_l;
    t_q16  r1_s;
    // stage 2: l*s, ramp factors
    t_q16  r2_prod;
    t_q16  r2_l;
    t_q16  r2_s;
    t_fac  r2_fac [NUM_CH];
    // stage 3: m1 and span
    t_q16  r3_m1;
    t_q16  r3_span;
    t_fac  r3_fac [NUM_CH];
    // stage 4: span * factor
    logic [28:0] r4_pr [NUM_CH];
    t_q16  r4_m1;
    // stage 5: ramp value above m1
    t_q16  r5_q [NUM_CH];
    t_q16  r5_m1;
    // stage 6: output register
    t_chan r6_ch [NUM_CH];

    // combinational next values
    t_hue        n1_hue [NUM_CH];
    t_hue        n1_hw;
    t_q16        n1_l;
    t_q16        n1_s;
    logic [33:0] n2_ls;
    logic [17:0] n3_m2;
    logic [17:0] n3_m1;
    logic [17:0] n3_span;
    logic [40:0] n5_full [NUM_CH];
    logic [17:0] n6_v [NUM_CH];
    t_chan       n6_ch [NUM_CH];

    // a stage moves when it is empty or the next one moves
    always_comb begin
        adv[NSTG-1] = ~r_vld[NSTG-1] | i_m_axis_tready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            adv[i] = ~r_vld[i] | adv[i+1];
        end
        n_vld[0] = adv[0] ? i_s_axis_tvalid : r_vld[0];
        for (int i = 1; i < NSTG; i++) begin
            n_vld[i] = adv[i] ? r_vld[i-1] : r_vld[i];
        end
    end

    assign o_s_axis_tready = adv[0];
    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign o_m_axis_tdata  = {r6_ch[CH_BLUE], r6_ch[CH_GREEN], r6_ch[CH_RED]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // stage 1: hue wrap, +120 / -120 degree offsets, clamp to one
    always_comb begin
        n1_hw  = wrap_turn({1'b0, i_s_axis_tdata[HUE_W-1:0]});
        n1_hue[CH_RED]   = wrap_turn({1'b0, n1_hw} + DEG120);
        n1_hue[CH_GREEN] = n1_hw;
        n1_hue[CH_BLUE]  = wrap_turn({1'b0, n1_hw} + DEG240);
        n1_l = i_s_axis_tdata[31:15];
        n1_s = i_s_axis_tdata[48:32];
        if (n1_l > ONE_Q16) begin
            n1_l = ONE_Q16;
        end
        if (n1_s > ONE_Q16) begin
            n1_s = ONE_Q16;
        end
    end

    // stages 2 and 3: l*s, then m2 by the lightness half rule, m1 = 2l - m2, span = m2 - m1
    always_comb begin
        n2_ls = r1_l * r1_s;
        if (r2_l < HALF_Q16) begin
            n3_m2 = {1'b0, r2_l} + {1'b0, r2_prod};
        end else begin
            n3_m2 = {1'b0, r2_l} + {1'b0, r2_s} - {1'b0, r2_prod};
        end
        n3_m1   = {r2_l, 1'b0} - n3_m2;
        n3_span = n3_m2 - n3_m1;
    end

    // stages 5 and 6: divide by 3840 = 256 * 15, add m1, scale by 65535/65536
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n5_full[c] = r4_pr[c][27:8] * RECIP15;
            n6_v[c]    = {1'b0, r5_m1} + {1'b0, r5_q[c]};
            // v*65535 >> 16 is v-1 for 0 < v <= one
            n6_ch[c]   = (n6_v[c] == 18'd0) ? '0 : n6_v[c][CH_W-1:0] - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_hue <= n1_hue;
            r1_l   <= n1_l;
            r1_s   <= n1_s;
        end
        if (adv[1]) begin
            r2_prod <= n2_ls[32:16];
            r2_l    <= r1_l;
            r2_s    <= r1_s;
            for (int c = 0; c < NUM_CH; c++) begin
                r2_fac[c] <= ramp_factor(r1_hue[c]);
            end
        end
        if (adv[2]) begin
            r3_m1   <= n3_m1[Q_W-1:0];
            r3_span <= n3_span[Q_W-1:0];
            r3_fac  <= r2_fac;
        end
        if (adv[3]) begin
            r4_m1 <= r3_m1;
            for (int c = 0; c < NUM_CH; c++) begin
                r4_pr[c] <= r3_span * r3_fac[c];
            end
        end
        if (adv[4]) begin
            r5_m1 <= r4_m1;
            for (int c = 0; c < NUM_CH; c++) begin
                r5_q[c] <= n5_full[c][RECIP_SH+Q_W-1:RECIP_SH];
            end
        end
        if (adv[5]) begin
            r6_ch <= n6_ch;
        end
    end

endmodule

>>> dv/hls2rgb_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hls2rgb_checker
// Watches both stream channels of the converter, predicts and compares RGB
// ----------------------------------------------------------------------------
// Every accepted HLS beat is turned into an expected RGB triple by a local
// fixed-point model. Every accepted RGB beat is compared field by field with
// the oldest expected triple. The mismatch count, the number of triples
// still in flight and the number of compared beats go back to the top.
// ----------------------------------------------------------------------------
module hls2rgb_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_hls_valid,
    input  logic                              i_hls_ready,
    // [14:0] hue, [31:15] lightness, [48:32] saturation, [55:49] zero
    input  logic [hls2rgb_pkg::S_TDATA_W-1:0] i_hls_data,
    input  logic                              i_rgb_valid,
    input  logic                              i_rgb_ready,
    // [15:0] red, [31:16] green, [47:32] blue
    input  logic [hls2rgb_pkg::M_TDATA_W-1:0] i_rgb_data,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_checked
);
    import hls2rgb_pkg::*;

    localparam int unsigned HUE_TURN = 23040;
    localparam int unsigned HUE_60   = 3840;
    localparam int unsigned HUE_120  = 7680;
    localparam int unsigned HUE_180  = 11520;
    localparam int unsigned HUE_240  = 15360;
    localparam int unsigned Q_ONE    = 65536;
    localparam int unsigned Q_HALF   = 32768;
    localparam int unsigned CHAN_MAX = 65535;

    typedef struct {
        t_hue  hue;
        t_q16  lightness;
        t_q16  saturation;
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_rgb_expect;

    t_rgb_expect exp_rgb_q[$];
    int          mismatches = 0;
    int          compared   = 0;

    function automatic int unsigned hue_wrap(input int unsigned h);
        return (h >= HUE_TURN) ? h - HUE_TURN : h;
    endfunction

    // ramp up, plateau, ramp down, floor
    function automatic int unsigned channel_level(input int unsigned lo, input int unsigned hi,
                                                  input int unsigned x);
        logic [63:0] span;
        logic [63:0] q;
        span = {32'd0, hi - lo};
        if (x < HUE_60) begin
            q = (span * x) / HUE_60;
            return lo + q[31:0];
        end else if (x < HUE_180) begin
            return hi;
        end else if (x < HUE_240) begin
            q = (span * (HUE_240 - x)) / HUE_60;
            return lo + q[31:0];
        end
        return lo;
    endfunction

    // Q1.16 level to a 16-bit channel, saturating at full scale
    function automatic t_chan level_to_chan(input int unsigned v);
        logic [63:0] c;
        c = ({32'd0, v} * CHAN_MAX) >> 16;
        return (c > CHAN_MAX) ? t_chan'(CHAN_MAX) : c[CH_W-1:0];
    endfunction

    function automatic t_rgb_expect predict_rgb(input t_hue hue_in, input t_q16 l_in,
                                                input t_q16 s_in);
        int unsigned h, l, s, prod, m1, m2, vr, vg, vb;
        logic [63:0] ls;
        t_rgb_expect e;
        h  = hue_wrap(int'(hue_in));
        l  = (l_in > Q_ONE) ? Q_ONE : int'(l_in);
        s  = (s_in > Q_ONE) ? Q_ONE : int'(s_in);
        ls = {32'd0, l} * {32'd0, s};
        prod = ls[47:16];
        m2 = (l < Q_HALF) ? l + prod : l + s - prod;
        m1 = 2 * l - m2;
        if (s == 0) begin
            vr = l;
            vg = l;
            vb = l;
        end else begin
            vr = channel_level(m1, m2, hue_wrap(h + HUE_120));
            vg = channel_level(m1, m2, h);
            vb = channel_level(m1, m2, hue_wrap(h + HUE_TURN - HUE_120));
        end
        e.hue        = hue_in;
        e.lightness  = l_in;
        e.saturation = s_in;
        e.red        = level_to_chan(vr);
        e.green      = level_to_chan(vg);
        e.blue       = level_to_chan(vb);
        return e;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t: rgb mismatch: %s", $time, what);
    endtask

    always @(posedge i_clk) begin
        t_rgb_expect e;
        t_chan       got_r, got_g, got_b;
        if (i_rst_n) begin
            // output side first: a beat leaving now can never stem from one entering now
            if (i_rgb_valid && i_rgb_ready) begin
                got_r = i_rgb_data[15:0];
                got_g = i_rgb_data[31:16];
                got_b = i_rgb_data[47:32];
                if (exp_rgb_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat r=%0d g=%0d b=%0d",
                                              got_r, got_g, got_b));
                end else begin
                    e = exp_rgb_q.pop_front();
                    compared++;
                    if (got_r !== e.red)
                        report_mismatch($sformatf("red h=%0d l=%0d s=%0d exp %0d got %0d",
                            e.hue, e.lightness, e.saturation, e.red, got_r));
                    if (got_g !== e.green)
                        report_mismatch($sformatf("green h=%0d l=%0d s=%0d exp %0d got %0d",
                            e.hue, e.lightness, e.saturation, e.green, got_g));
                    if (got_b !== e.blue)
                        report_mismatch($sformatf("blue h=%0d l=%0d s=%0d exp %0d got %0d",
                            e.hue, e.lightness, e.saturation, e.blue, got_b));
                end
            end
            if (i_hls_valid && i_hls_ready) begin
                exp_rgb_q.push_back(predict_rgb(i_hls_data[14:0], i_hls_data[31:15],
                                                i_hls_data[48:32]));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= exp_rgb_q.size();
        o_checked    <= compared;
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream stimulus and verdict for the HLS to RGB converter
// ----------------------------------------------------------------------------
// Sends a directed set of corner pixels (hue at zero and on the 60, 120, 180
// and 240 degree boundaries, hue wrap, gray, clamped lightness and saturation)
// and then a mostly in-range random pixel stream with some full-width noise. Both stream
// sides idle at random, except for a stretch in the middle where they run
// flat out. The checker beside the converter does all the comparing.
// ----------------------------------------------------------------------------
module tb_top;
    import hls2rgb_pkg::*;

    localparam int RANDOM_BEATS = 900;
    localparam int IDLE_PCT     = 31;
    localparam int DRAIN_CYCLES = 20;   // pipeline is six deep, plus margin

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 hls_valid;
    logic                 hls_ready;
    // [14:0] hue, [31:15] lightness, [48:32] saturation, [55:49] zero
    logic [S_TDATA_W-1:0] hls_data;
    logic                 rgb_valid;
    logic                 rgb_ready;
    // [15:0] red, [31:16] green, [47:32] blue
    logic [M_TDATA_W-1:0] rgb_data;

    logic quiet_stretch = 1'b0;   // no idling on either side while set
    int   fail_count;
    int   rgb_pending;
    int   rgb_checked;
    int   sent_beats   = 0;
    int   directed_cnt = 0;
    int   wild_cnt     = 0;       // beats with fields beyond their legal range

    hls_to_rgb_converter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (hls_valid),
        .o_s_axis_tready (hls_ready),
        .i_s_axis_tdata  (hls_data),
        .o_m_axis_tvalid (rgb_valid),
        .i_m_axis_tready (rgb_ready),
        .o_m_axis_tdata  (rgb_data)
    );

    hls2rgb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hls_valid  (hls_valid),
        .i_hls_ready  (hls_ready),
        .i_hls_data   (hls_data),
        .i_rgb_valid  (rgb_valid),
        .i_rgb_ready  (rgb_ready),
        .i_rgb_data   (rgb_data),
        .o_fail_count (fail_count),
        .o_pending    (rgb_pending),
        .o_checked    (rgb_checked)
    );

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // output side back-pressure
    initial begin
        rgb_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (quiet_stretch) begin
                rgb_ready <= 1'b1;
            end else begin
                rgb_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // one hls beat: optional idle gap, then hold valid until the handshake
    task automatic send_hls(input t_hue hue, input t_q16 l, input t_q16 s);
        if (!quiet_stretch) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                hls_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        hls_valid <= 1'b1;
        hls_data  <= {7'd0, s, l, hue};
        @(posedge i_clk);
        while (!hls_ready) @(posedge i_clk);
        sent_beats++;
        if (hue >= t_hue'(23040) || l > ONE_Q16 || s > ONE_Q16) wild_cnt++;
    endtask

    // Q1.16 pick with weight on zero, one and the one-half split
    function automatic t_q16 pick_q16();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 10) return '0;
        if (sel < 20) return ONE_Q16;
        if (sel < 30) return t_q16'($urandom_range(32770, 32766));
        return t_q16'($urandom_range(65536));
    endfunction

    initial begin
        int unsigned sel;
        int          hue_int;
        t_hue        hue;
        t_q16        l, s;

        i_rst_n   <= 1'b0;
        hls_valid <= 1'b0;
        hls_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners: pure hues at zero and on the 60, 120, 180 and 240 degree boundaries
        send_hls(15'd0,     17'd32768, 17'd65536);
        send_hls(15'd3839,  17'd32768, 17'd65536);
        send_hls(15'd3840,  17'd32768, 17'd65536);
        send_hls(15'd7680,  17'd32768, 17'd65536);
        send_hls(15'd11519, 17'd32768, 17'd65536);
        send_hls(15'd11520, 17'd32768, 17'd65536);
        send_hls(15'd15359, 17'd32768, 17'd65536);
        send_hls(15'd15360, 17'd32768, 17'd65536);
        send_hls(15'd23039, 17'd32768, 17'd65536);
        // hue of a full turn or more wraps once
        send_hls(15'd23040, 17'd20000, 17'd50000);
        send_hls(15'd32767, 17'd20000, 17'd50000);
        // lightness on both sides of one half, and its extremes
        send_hls(15'd1000,  17'd32767, 17'd40000);
        send_hls(15'd1000,  17'd32768, 17'd40000);
        send_hls(15'd5000,  17'd0,     17'd65536);
        send_hls(15'd5000,  17'd65536, 17'd65536);
        // zero saturation gives gray
        send_hls(15'd9000,  17'd0,     17'd0);
        send_hls(15'd9000,  17'd45678, 17'd0);
        send_hls(15'd9000,  17'd65536, 17'd0);
        // lightness and saturation above one clamp to one
        send_hls(15'd2500,  17'd131071, 17'd30000);
        send_hls(15'd2500,  17'd20000,  17'd131071);
        send_hls(15'd32767, 17'd131071, 17'd131071);
        send_hls(15'd18000, 17'd65535,  17'd1);
        directed_cnt = sent_beats;

        for (int i = 0; i < RANDOM_BEATS; i++) begin
            // flat-out stretch in the middle of the random part
            quiet_stretch = (i >= 350 && i < 550);
            sel = $urandom_range(99);
            if (sel < 15) begin
                // full-width noise, including out of range fields
                hue = t_hue'($urandom_range(32767));
                l   = t_q16'($urandom_range(131071));
                s   = t_q16'($urandom_range(131071));
            end else begin
                if (sel < 40) begin
                    // a hue right at a sector boundary
                    hue_int = int'($urandom_range(5)) * 3840 + int'($urandom_range(2)) - 1;
                    if (hue_int < 0) hue_int = 0;
                    hue = t_hue'(hue_int);
                end else begin
                    hue = t_hue'($urandom_range(23039));
                end
                l = pick_q16();
                s = pick_q16();
            end
            send_hls(hue, l, s);
        end
        quiet_stretch = 1'b0;
        hls_valid <= 1'b0;

        // drain: let the checker see the last push, then wait for every result
        @(posedge i_clk);
        while (rgb_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d hls beats (%0d directed corners, %0d with out of range fields)",
                 sent_beats, directed_cnt, wild_cnt);
        $display("compared %0d rgb beats under random stalls on both sides, %0d mismatches",
                 rgb_checked, fail_count);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/hls2rgb_pkg.sv
rtl/core/hls_to_rgb_converter.sv
dv/hls2rgb_checker.sv
dv/tb_top.sv
